// File: hdl/tcc_pkg.sv
`default_nettype none
package tcc_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int EXTRA_FRAC_DEF = 8;
    localparam int OUT_W = 32;
    localparam logic [OUT_W-1:0] OUT_MAX = 32'h7fff_ffff;
    localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic degenerate;
        logic saturated;
    } flags_t;
endpackage
`default_nettype wire

// File: hdl/tcc_front.sv
`default_nettype none
module tcc_front #(
    parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF,
    parameter int DF = COORD_BITS + 1,
    parameter int SQ = 2 * DF + 1,
    parameter int DW = 2 * DF + 2,
    parameter int NW = DF + SQ + 1
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire signed [COORD_BITS-1:0]  ax,
    input  wire signed [COORD_BITS-1:0]  ay,
    input  wire signed [COORD_BITS-1:0]  bx,
    input  wire signed [COORD_BITS-1:0]  by_coord,
    input  wire signed [COORD_BITS-1:0]  cx,
    input  wire signed [COORD_BITS-1:0]  cy,
    output logic                         out_valid,
    output logic signed [NW-1:0]         nx,
    output logic signed [NW-1:0]         ny,
    output logic signed [DW-1:0]         d,
    output logic signed [COORD_BITS-1:0] ax_o,
    output logic signed [COORD_BITS-1:0] ay_o
);
    localparam int C = COORD_BITS;
    localparam int NS = 5;

    logic [NS-1:0] vld_reg;
    logic signed [C-1:0] ax_reg [0:NS-1];
    logic signed [C-1:0] ay_reg [0:NS-1];

    // stage 1: translate to A at origin
    logic signed [DF-1:0] bxr_reg, byr_reg, cxr_reg, cyr_reg;
    // stage 2: products
    logic signed [DF-1:0] bxr2_reg, byr2_reg, cxr2_reg, cyr2_reg;
    logic signed [2*DF-1:0] bb_reg, yy_reg, cc_reg, zz_reg, bc_reg, yc_reg;
    // stage 3: squared lengths and D
    logic signed [DF-1:0] bxr3_reg, byr3_reg, cxr3_reg, cyr3_reg;
    logic signed [SQ-1:0] sb_reg, sc_reg;
    logic signed [DW-1:0] d3_reg;
    // stage 4: numerator products
    logic signed [DF+SQ-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [DW-1:0] d4_reg;
    // stage 5: numerators
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic signed [DW-1:0] d5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg[0] <= ax;
            ay_reg[0] <= ay;
            for (int i = 1; i < NS; i++) begin
                ax_reg[i] <= ax_reg[i-1];
                ay_reg[i] <= ay_reg[i-1];
            end
            bxr_reg <= {bx[C-1], bx} - {ax[C-1], ax};
            byr_reg <= {by_coord[C-1], by_coord} - {ay[C-1], ay};
            cxr_reg <= {cx[C-1], cx} - {ax[C-1], ax};
            cyr_reg <= {cy[C-1], cy} - {ay[C-1], ay};

            bxr2_reg <= bxr_reg;
            byr2_reg <= byr_reg;
            cxr2_reg <= cxr_reg;
            cyr2_reg <= cyr_reg;
            bb_reg <= bxr_reg * bxr_reg;
            yy_reg <= byr_reg * byr_reg;
            cc_reg <= cxr_reg * cxr_reg;
            zz_reg <= cyr_reg * cyr_reg;
            bc_reg <= bxr_reg * cyr_reg;
            yc_reg <= byr_reg * cxr_reg;

            bxr3_reg <= bxr2_reg;
            byr3_reg <= byr2_reg;
            cxr3_reg <= cxr2_reg;
            cyr3_reg <= cyr2_reg;
            sb_reg <= SQ'(bb_reg) + SQ'(yy_reg);
            sc_reg <= SQ'(cc_reg) + SQ'(zz_reg);
            d3_reg <= (DW'(bc_reg) - DW'(yc_reg)) <<< 1;

            m1_reg <= cyr3_reg * sb_reg;
            m2_reg <= byr3_reg * sc_reg;
            m3_reg <= bxr3_reg * sc_reg;
            m4_reg <= cxr3_reg * sb_reg;
            d4_reg <= d3_reg;

            nx_reg <= NW'(m1_reg) - NW'(m2_reg);
            ny_reg <= NW'(m3_reg) - NW'(m4_reg);
            d5_reg <= d4_reg;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign nx = nx_reg;
    assign ny = ny_reg;
    assign d = d5_reg;
    assign ax_o = ax_reg[NS-1];
    assign ay_o = ay_reg[NS-1];
endmodule
`default_nettype wire

// File: hdl/tcc_div.sv
`default_nettype none
module tcc_div #(
    parameter int NW = 53,
    parameter int DW = 36,
    parameter int EXTRA_FRAC_BITS = tcc_pkg::EXTRA_FRAC_DEF,
    parameter int TW = 16,
    parameter int QN = NW + EXTRA_FRAC_BITS
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  en,
    input  wire                  in_valid,
    input  wire signed [NW-1:0]  n,
    input  wire signed [DW-1:0]  d,
    input  wire [TW-1:0]         tag,
    output logic                 out_valid,
    output logic signed [QN:0]   q,
    output logic [TW-1:0]        tag_o
);
    // restoring long division, one quotient bit per stage
    logic [QN-1:0] dvd_reg [0:QN];
    logic [DW-1:0] rem_reg [0:QN];
    logic [DW-1:0] dvs_reg [0:QN];
    logic [QN-1:0] quo_reg [0:QN];
    logic [TW-1:0] tag_reg [0:QN];
    logic [QN:0]   neg_reg;
    logic [QN+1:0] vld_reg;
    logic signed [QN:0] q_reg;
    logic [TW-1:0] tagq_reg;

    logic [NW-1:0] nmag;
    logic [DW-1:0] dmag;
    assign nmag = n[NW-1] ? NW'(-n) : NW'(n);
    assign dmag = d[DW-1] ? DW'(-d) : DW'(d);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QN:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd_reg[0] <= {nmag, {EXTRA_FRAC_BITS{1'b0}}};
            rem_reg[0] <= '0;
            dvs_reg[0] <= dmag;
            quo_reg[0] <= '0;
            tag_reg[0] <= tag;
            neg_reg[0] <= n[NW-1] ^ d[DW-1];
        end
    end

    for (genvar k = 0; k < QN; k++) begin : g_step
        logic [DW:0] trial;
        logic        ge;
        logic [DW:0] diff;
        assign trial = {rem_reg[k], dvd_reg[k][QN-1]};
        assign ge = trial >= {1'b0, dvs_reg[k]};
        assign diff = trial - {1'b0, dvs_reg[k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                dvd_reg[k+1] <= dvd_reg[k] << 1;
                quo_reg[k+1] <= {quo_reg[k][QN-2:0], ge};
                dvs_reg[k+1] <= dvs_reg[k];
                tag_reg[k+1] <= tag_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= neg_reg[QN] ? -$signed({1'b0, quo_reg[QN]})
                                 : $signed({1'b0, quo_reg[QN]});
            tagq_reg <= tag_reg[QN];
        end
    end

    assign out_valid = vld_reg[QN+1];
    assign q = q_reg;
    assign tag_o = tagq_reg;
endmodule
`default_nettype wire

// File: hdl/tcc_back.sv
`default_nettype none
module tcc_back #(
    parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF,
    parameter int EXTRA_FRAC_BITS = tcc_pkg::EXTRA_FRAC_DEF,
    parameter int QW = 62
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire signed [QW-1:0]          qx,
    input  wire signed [QW-1:0]          qy,
    input  wire signed [COORD_BITS-1:0]  ax,
    input  wire signed [COORD_BITS-1:0]  ay,
    input  wire                          degenerate,
    output logic                         out_valid,
    output logic [tcc_pkg::OUT_W-1:0]    center_x,
    output logic [tcc_pkg::OUT_W-1:0]    center_y,
    output tcc_pkg::flags_t              flags
);
    localparam int OW = tcc_pkg::OUT_W;
    localparam int SW = QW + 1;

    logic signed [SW-1:0] sx, sy;
    logic px, nx_o, py, ny_o;
    logic [OW-1:0] cx_next, cy_next;
    logic vld_reg;
    logic [OW-1:0] cx_reg, cy_reg;
    tcc_pkg::flags_t flags_reg;

    assign sx = SW'(qx) + (SW'(ax) <<< EXTRA_FRAC_BITS);
    assign sy = SW'(qy) + (SW'(ay) <<< EXTRA_FRAC_BITS);
    // out of range when the bits above the 32-bit sign do not all match it
    assign px = !sx[SW-1] && (|sx[SW-2:OW-1]);
    assign nx_o = sx[SW-1] && !(&sx[SW-2:OW-1]);
    assign py = !sy[SW-1] && (|sy[SW-2:OW-1]);
    assign ny_o = sy[SW-1] && !(&sy[SW-2:OW-1]);

    always_comb begin
        cx_next = px ? tcc_pkg::OUT_MAX : (nx_o ? tcc_pkg::OUT_MIN : sx[OW-1:0]);
        cy_next = py ? tcc_pkg::OUT_MAX : (ny_o ? tcc_pkg::OUT_MIN : sy[OW-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (degenerate) begin
                cx_reg <= '0;
                cy_reg <= '0;
                flags_reg.degenerate <= 1'b1;
                flags_reg.saturated <= 1'b0;
            end else begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                flags_reg.degenerate <= 1'b0;
                flags_reg.saturated <= px | nx_o | py | ny_o;
            end
        end
    end

    assign out_valid = vld_reg;
    assign center_x = cx_reg;
    assign center_y = cy_reg;
    assign flags = flags_reg;
endmodule
`default_nettype wire

// File: hdl/triangle_circumcenter_unit.sv
// Triangle circumcenter, streaming pipeline.
// Slave channel: one triangle per transaction, s_tdata holds ax, ay, bx,
// by_coord, cx, cy, each COORD_BITS signed, from the lowest bit up.
// Master channel: m_tdata holds center_x then center_y (32 bits signed each,
// EXTRA_FRAC_BITS more fraction bits than the input); m_tuser holds
// degenerate (bit 0) and saturated (bit 1).
// Steps: differences, products, squared lengths and D, numerator products
// and numerators; two parallel long dividers, each with an input register,
// one quotient bit per stage and a sign fix; a registered offset add and clamp.
// Throughput: one triangle per cycle while the receiver takes results.
// Reset clears all valid bits; the pipeline is empty after reset.
// When the receiver stalls with a result held, the whole pipeline freezes
// and s_tready drops; empty stages still fill while no result is waiting,
// so nothing is lost or repeated.
`default_nettype none
module triangle_circumcenter_unit #(
    parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF,
    parameter int EXTRA_FRAC_BITS = tcc_pkg::EXTRA_FRAC_DEF,
    parameter int IN_W = ((6 * COORD_BITS + 7) / 8) * 8
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_tvalid,
    output logic            s_tready,
    input  wire [IN_W-1:0]  s_tdata,   // ax, ay, bx, by_coord, cx, cy
    output logic            m_tvalid,
    input  wire             m_tready,
    output logic [63:0]     m_tdata,   // center_x, center_y
    output logic [1:0]      m_tuser    // degenerate, saturated
);
    localparam int C = COORD_BITS;
    localparam int DF = C + 1;
    localparam int SQ = 2 * DF + 1;
    localparam int DW = 2 * DF + 2;
    localparam int NW = DF + SQ + 1;
    localparam int QN = NW + EXTRA_FRAC_BITS;

    logic en;
    assign en = m_tready || !m_tvalid;
    assign s_tready = en;

    logic f_valid;
    logic signed [NW-1:0] f_nx, f_ny;
    logic signed [DW-1:0] f_d;
    logic signed [C-1:0] f_ax, f_ay;

    tcc_front #(.COORD_BITS(C), .DF(DF), .SQ(SQ), .DW(DW), .NW(NW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid && en),
        .ax(s_tdata[C-1:0]), .ay(s_tdata[2*C-1:C]),
        .bx(s_tdata[3*C-1:2*C]), .by_coord(s_tdata[4*C-1:3*C]),
        .cx(s_tdata[5*C-1:4*C]), .cy(s_tdata[6*C-1:5*C]),
        .out_valid(f_valid), .nx(f_nx), .ny(f_ny), .d(f_d),
        .ax_o(f_ax), .ay_o(f_ay)
    );

    logic dx_valid;
    logic dy_valid;
    logic signed [QN:0] qx, qy;
    logic [C:0] tag_x;
    logic [C-1:0] tag_y;

    tcc_div #(.NW(NW), .DW(DW), .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS), .TW(C + 1),
              .QN(QN)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(f_valid), .n(f_nx), .d(f_d),
        .tag({(f_d == '0), f_ax}),
        .out_valid(dx_valid), .q(qx), .tag_o(tag_x)
    );

    tcc_div #(.NW(NW), .DW(DW), .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS), .TW(C),
              .QN(QN)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(f_valid), .n(f_ny), .d(f_d), .tag(f_ay),
        .out_valid(dy_valid), .q(qy), .tag_o(tag_y)
    );

    logic [31:0] cxo, cyo;
    tcc_pkg::flags_t flg;

    tcc_back #(.COORD_BITS(C), .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS), .QW(QN + 1)) u_back (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(dx_valid), .qx(qx), .qy(qy),
        .ax(tag_x[C-1:0]), .ay(tag_y), .degenerate(tag_x[C]),
        .out_valid(m_tvalid), .center_x(cxo), .center_y(cyo), .flags(flg)
    );

    assign m_tdata = {cyo, cxo};
    assign m_tuser = {flg.saturated, flg.degenerate};

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("degenerate and saturated both set");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("degenerate result with nonzero center");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        dx_valid == dy_valid)
        else $error("dividers out of step");
endmodule
`default_nettype wire
